// ===== design/pwmss_pkg.sv =====
// Package with the shared widths, codes, types and symbol decoding of the PWM window scorer.
`default_nettype none

package pwmss_pkg;

	localparam int MAX_MOTIF_LENGTH_DEF = 32;
	localparam int WEIGHT_WIDTH_DEF     = 16;

	localparam int ROW_W       = 5;
	localparam int BASE_W      = 2;
	localparam int VALUE_W     = 16;
	localparam int SYM_W       = 8;
	localparam int MOTIF_LEN_W = 6;
	localparam int SCORE_W     = 21;
	localparam int POS_W       = 16;
	localparam int STATUS_W    = 2;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SYMBOL = 1'b1;

	localparam logic [SYM_W-1:0] CH_A = 8'h41;
	localparam logic [SYM_W-1:0] CH_C = 8'h43;
	localparam logic [SYM_W-1:0] CH_G = 8'h47;
	localparam logic [SYM_W-1:0] CH_U = 8'h55;
	localparam logic [SYM_W-1:0] CH_T = 8'h54;

	localparam logic [BASE_W-1:0] BASE_A = 2'd0;
	localparam logic [BASE_W-1:0] BASE_C = 2'd1;
	localparam logic [BASE_W-1:0] BASE_G = 2'd2;
	localparam logic [BASE_W-1:0] BASE_U = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_SCORE   = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BADCHAR = 2'd2
	} status_t;

	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] base;
	} base_dec_t;

	typedef struct packed {
		logic              shift;
		logic              clear;
		logic              emit;
		status_t           status;
		logic [POS_W-1:0]  start;
		logic              last;
		logic [BASE_W-1:0] base;
	} seq_ctl_t;

	function automatic base_dec_t decode_base(input logic [SYM_W-1:0] sym);
		base_dec_t d;
		d.ok = 1'b1;
		case (sym)
			CH_A: d.base = BASE_A;
			CH_C: d.base = BASE_C;
			CH_G: d.base = BASE_G;
			CH_U: d.base = BASE_U;
			CH_T: d.base = BASE_U;
			default: begin
				d.ok   = 1'b0;
				d.base = BASE_A;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== design/pwmss_cell.sv =====
// One cell of the scoring chain: the four weights of one matrix row and one partial sum.
`default_nettype none

module pwmss_cell #(
	parameter int WEIGHT_WIDTH = pwmss_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  wr_en,
	input  wire logic [pwmss_pkg::BASE_W-1:0]          wr_base,
	input  wire logic signed [WEIGHT_WIDTH-1:0]        wr_value,
	input  wire logic                                  shift,
	input  wire logic                                  clear,
	input  wire logic [pwmss_pkg::BASE_W-1:0]          base,
	input  wire logic signed [pwmss_pkg::SCORE_W-1:0]  sum_in,
	output logic signed [pwmss_pkg::SCORE_W-1:0]       sum_next,
	output logic signed [pwmss_pkg::SCORE_W-1:0]       sum_q
);
	import pwmss_pkg::*;

	logic signed [WEIGHT_WIDTH-1:0] w_q [2**BASE_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[wr_base] <= wr_value;
		end
	end

	assign sum_next = sum_in + SCORE_W'(w_q[base]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_next;
		end
	end

endmodule

`default_nettype wire

// ===== design/pwmss_ctrl.sv =====
// Sequence control: symbol decoding, position count, discard state and result decision.
`default_nettype none

module pwmss_ctrl #(
	parameter int MAX_MOTIF_LENGTH = pwmss_pkg::MAX_MOTIF_LENGTH_DEF,
	localparam int IDX_W = (MAX_MOTIF_LENGTH > 1) ? $clog2(MAX_MOTIF_LENGTH) : 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sym_acc,
	input  wire logic [pwmss_pkg::SYM_W-1:0]         symbol,
	input  wire logic                                eos,
	input  wire logic [pwmss_pkg::MOTIF_LEN_W-1:0]   motif_len,
	output pwmss_pkg::seq_ctl_t                      ctl,
	output logic [IDX_W-1:0]                         sel
);
	import pwmss_pkg::*;

	localparam int LEN_W = MOTIF_LEN_W + 1;
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MOTIF_LENGTH);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	logic [POS_W-1:0] seen_q;
	logic             discard_q;
	base_dec_t        dec;
	logic [LEN_W-1:0] cfg_ext;
	logic [LEN_W-1:0] len;
	logic [POS_W:0]   pos_inc;
	logic             full;
	logic [POS_W-1:0] start;

	always_comb begin
		dec     = decode_base(symbol);
		cfg_ext = {1'b0, motif_len};
		if (motif_len == '0) begin
			len = LEN_ONE;
		end else if (cfg_ext > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = cfg_ext;
		end
		sel     = IDX_W'(len - LEN_ONE);
		pos_inc = {1'b0, seen_q} + (POS_W+1)'(1);
		full    = pos_inc >= (POS_W+1)'(len);
		start   = (seen_q == POS_MAX) ? POS_MAX : POS_W'(pos_inc - (POS_W+1)'(len));
	end

	always_comb begin
		ctl        = '0;
		ctl.status = ST_SCORE;
		ctl.base   = dec.base;
		if (sym_acc) begin
			if (discard_q) begin
				ctl.clear = eos;
			end else if (!dec.ok) begin
				ctl.emit   = 1'b1;
				ctl.status = ST_BADCHAR;
				ctl.start  = seen_q;
				ctl.last   = 1'b1;
				ctl.clear  = eos;
			end else begin
				ctl.shift = 1'b1;
				ctl.clear = eos;
				if (full) begin
					ctl.emit  = 1'b1;
					ctl.start = start;
					ctl.last  = eos;
				end else if (eos) begin
					ctl.emit   = 1'b1;
					ctl.status = ST_SHORT;
					ctl.last   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			discard_q <= 1'b0;
		end else if (ctl.clear) begin
			seen_q    <= '0;
			discard_q <= 1'b0;
		end else if (sym_acc && !discard_q && !dec.ok) begin
			discard_q <= 1'b1;
		end else if (ctl.shift && seen_q != POS_MAX) begin
			seen_q <= seen_q + POS_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/pwm_sliding_window_scorer.sv =====
// Top level of the position weight matrix window scorer.
`default_nettype none
// The input stream carries two kinds of item, chosen by s_tuser. A load item writes one
// weight of the matrix into the cell of its row; a symbol item carries one character of
// a sequence, with s_tlast set on the last character of each sequence.
// Every symbol item is applied to a chain of cells, one per matrix row, that adds the
// symbol's weight to the partial sum handed on by the previous cell. One item is taken
// in every cycle while s_tready is high; the chain and the final score selection settle within that cycle.
// A result is registered in the output stage and appears on the master side in the cycle
// after its item is accepted. Load items and symbols that complete no window produce no
// result, but a sequence that ends before its first window yields a short result. An invalid
// character yields an error result and the rest of its sequence is dropped up to its end.
// The motif length register is written through cfg_we and cfg_wdata; the user must
// write it only while idle, which the block does not enforce. Reset clears the partial
// sums, position count and drop state, sets motif length to one; weights are not reset.
// When the receiver stalls, the held result stays on the master side and s_tready drops
// until that result is taken; s_tready is high whenever the output stage is empty or
// being emptied in the same cycle.

module pwm_sliding_window_scorer #(
	parameter int MAX_MOTIF_LENGTH = pwmss_pkg::MAX_MOTIF_LENGTH_DEF,
	parameter int WEIGHT_WIDTH     = pwmss_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// weight_row[4:0], weight_base[6:5], weight_value[22:7], symbol[30:23], zero fill
	input  wire logic [31:0]                        s_tdata,
	// action
	input  wire logic                               s_tuser,
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// score[20:0], window_start[36:21], zero fill
	output logic [39:0]                             m_tdata,
	// status
	output logic [pwmss_pkg::STATUS_W-1:0]          m_tuser,
	output logic                                    m_tlast,
	input  wire logic                               cfg_we,
	input  wire logic [pwmss_pkg::MOTIF_LEN_W-1:0]  cfg_wdata
);
	import pwmss_pkg::*;

	localparam int IDX_W = (MAX_MOTIF_LENGTH > 1) ? $clog2(MAX_MOTIF_LENGTH) : 1;

	logic [MOTIF_LEN_W-1:0]     motif_q;
	logic                       s_acc;
	logic                       sym_acc;
	logic                       load_acc;
	logic [ROW_W-1:0]           weight_row;
	logic [BASE_W-1:0]          weight_base;
	logic signed [VALUE_W-1:0]  weight_value;
	logic [SYM_W-1:0]           symbol;
	logic signed [WEIGHT_WIDTH-1:0] wr_value;
	seq_ctl_t                   ctl;
	logic [IDX_W-1:0]           sel;
	logic signed [SCORE_W-1:0]  sum_next [MAX_MOTIF_LENGTH];
	logic signed [SCORE_W-1:0]  sum_q    [MAX_MOTIF_LENGTH];
	logic signed [SCORE_W-1:0]  score;

	logic                       m_valid_q;
	logic [SCORE_W-1:0]         score_q;
	logic [POS_W-1:0]           start_q;
	status_t                    status_q;
	logic                       last_q;

	assign weight_row   = s_tdata[4:0];
	assign weight_base  = s_tdata[6:5];
	assign weight_value = s_tdata[22:7];
	assign symbol       = s_tdata[30:23];
	assign wr_value     = WEIGHT_WIDTH'(weight_value);

	assign s_tready = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign sym_acc  = s_acc && (s_tuser == ACT_SYMBOL);
	assign load_acc = s_acc && (s_tuser == ACT_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_q <= MOTIF_LEN_W'(1);
		end else if (cfg_we) begin
			motif_q <= cfg_wdata;
		end
	end

	pwmss_ctrl #(
		.MAX_MOTIF_LENGTH(MAX_MOTIF_LENGTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_acc  (sym_acc),
		.symbol   (symbol),
		.eos      (s_tlast),
		.motif_len(motif_q),
		.ctl      (ctl),
		.sel      (sel)
	);

	for (genvar k = 0; k < MAX_MOTIF_LENGTH; k++) begin : g_cell
		logic signed [SCORE_W-1:0] sum_in;
		if (k == 0) begin : g_first
			assign sum_in = '0;
		end else begin : g_rest
			assign sum_in = sum_q[k-1];
		end
		pwmss_cell #(
			.WEIGHT_WIDTH(WEIGHT_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (load_acc && (32'(weight_row) == k)),
			.wr_base (weight_base),
			.wr_value(wr_value),
			.shift   (ctl.shift),
			.clear   (ctl.clear),
			.base    (ctl.base),
			.sum_in  (sum_in),
			.sum_next(sum_next[k]),
			.sum_q   (sum_q[k])
		);
	end

	assign score = (ctl.status == ST_SCORE) ? sum_next[sel] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc && ctl.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && ctl.emit) begin
			score_q  <= score;
			start_q  <= ctl.start;
			status_q <= ctl.status;
			last_q   <= ctl.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, start_q, score_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && ctl.emit) |=> m_tvalid)
		else $error("accepted item with a result did not reach the output stage");

	a_badchar_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_BADCHAR) |-> m_tlast)
		else $error("invalid character result not marked last of sequence");

	a_status_zero_score: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_SCORE) |-> (m_tdata[SCORE_W-1:0] == '0))
		else $error("status result carries a nonzero score");

	a_no_emit_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |-> !ctl.emit && !ctl.shift && !ctl.clear)
		else $error("load item disturbed the sequence state");

endmodule

`default_nettype wire
